>>> src/hid_keyboard_rollover_table_macros.svh
// assertion helpers for the rollover table
`ifndef HID_KEYBOARD_ROLLOVER_TABLE_MACROS_SVH
`define HID_KEYBOARD_ROLLOVER_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define HKRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define HKRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/hkrt_pkg.sv
`default_nettype none

package hkrt_pkg;

   localparam int SLOT_COUNT   = 6;
   localparam int REPORT_SLOTS = 6;
   localparam int CODE_W       = 8;

   localparam logic [CODE_W-1:0] CODE_NONE     = 8'h00;
   localparam logic [CODE_W-1:0] CODE_ROLLOVER = 8'h01;
   localparam logic [7:0]        REPORT_ID_RST = 8'h01;

   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_PRESS   = 2'd1,
      CMD_RELEASE = 2'd2
   } cmd_type;

   // controller to datapath
   typedef struct packed {
      logic load;
   } ctl_cmd_type;

   typedef struct packed {
      logic [7:0]                           tag;
      logic [7:0]                           mods;
      logic [REPORT_SLOTS-1:0][CODE_W-1:0] codes;
   } report_type;

endpackage

`default_nettype wire

>>> src/hkrt_chan_if.sv
`default_nettype none

interface hkrt_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] key_code;
   logic [7:0] modifier_bits;

   modport source (output valid, command, key_code, modifier_bits, input ready);
   modport sink   (input valid, command, key_code, modifier_bits, output ready);
endinterface

interface hkrt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] report_tag;
   logic [7:0] report_modifiers;
   logic [7:0] slot_code_0;
   logic [7:0] slot_code_1;
   logic [7:0] slot_code_2;
   logic [7:0] slot_code_3;
   logic [7:0] slot_code_4;
   logic [7:0] slot_code_5;

   modport source (output valid, report_tag, report_modifiers, slot_code_0, slot_code_1,
                   slot_code_2, slot_code_3, slot_code_4, slot_code_5, input ready);
   modport sink   (input valid, report_tag, report_modifiers, slot_code_0, slot_code_1,
                   slot_code_2, slot_code_3, slot_code_4, slot_code_5, output ready);
endinterface

`default_nettype wire

>>> src/hid_keyboard_rollover_table.sv
`default_nettype none
// key-code slot table of a boot keyboard with six-key rollover
// req_if carries one event word: command (clear, press, release), key_code and
//    modifier_bits; rsp_if returns one keyboard report word for every event:
//    report_tag, report_modifiers and slot_code_0 to slot_code_5
// csr_wr_en / csr_wr_data write the report id, copied into every report
// latency: a report is valid on rsp_if the cycle after its event is accepted
// throughput: one event per cycle unless a held report stalls; the slot compares,
//    lowest-free pick and slot update are combinational before the report register
// a single report register holds the last result; while it waits and rsp_if.ready
//    is low, req_if.ready is low too, so no event is taken until the report leaves
// when the report is taken in the same cycle, a new event is accepted at once
// reset clears all slots, sets the report id to 1 and drops rsp_if.valid;
//    no clearing sequence follows, events are taken from the first cycle after
module hid_keyboard_rollover_table
   import hkrt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   hkrt_req_if.sink    req_if,
   hkrt_rsp_if.source  rsp_if,
   input  wire logic   csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   `include "hid_keyboard_rollover_table_macros.svh"

   ctl_cmd_type ctl_cmd;
   report_type  report;

   hkrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .ctl_cmd   (ctl_cmd)
   );

   hkrt_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl_cmd       (ctl_cmd),
      .command       (req_if.command),
      .key_code      (req_if.key_code),
      .modifier_bits (req_if.modifier_bits),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .report        (report)
   );

   assign rsp_if.report_tag       = report.tag;
   assign rsp_if.report_modifiers = report.mods;
   assign rsp_if.slot_code_0      = report.codes[0];
   assign rsp_if.slot_code_1      = report.codes[1];
   assign rsp_if.slot_code_2      = report.codes[2];
   assign rsp_if.slot_code_3      = report.codes[3];
   assign rsp_if.slot_code_4      = report.codes[4];
   assign rsp_if.slot_code_5      = report.codes[5];

   `HKRT_ASSERT_NEXT(a_accept_gives_report, clock, reset,
      req_if.valid && req_if.ready, rsp_if.valid, "accepted event gave no report")
   `HKRT_ASSERT_NOW(a_stall_blocks_input, clock, reset,
      rsp_if.valid && !rsp_if.ready, !req_if.ready, "event taken while report stalled")
   `HKRT_ASSERT_NEXT(a_clear_empties, clock, reset,
      req_if.valid && req_if.ready && (req_if.command == CMD_CLEAR),
      (rsp_if.report_modifiers == 8'h00) && (rsp_if.slot_code_0 == CODE_NONE)
         && (rsp_if.slot_code_5 == CODE_NONE),
      "clear left keys or modifiers")

endmodule

`default_nettype wire

>>> src/hkrt_ctrl.sv
`default_nettype none

module hkrt_ctrl
   import hkrt_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire logic  rsp_ready,
   output ctl_cmd_type ctl_cmd
);

   typedef enum logic {
      ST_EMPTY,
      ST_FULL
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // a new word may enter in the same cycle the held report leaves
   assign req_ready    = !reset && ((state_ff == ST_EMPTY) || rsp_ready);
   assign accept       = req_valid && req_ready;
   assign rsp_valid    = (state_ff == ST_FULL);
   assign ctl_cmd.load = accept;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_EMPTY: begin
            if (accept) state_in = ST_FULL;
         end
         ST_FULL: begin
            if (accept)         state_in = ST_FULL;
            else if (rsp_ready) state_in = ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> src/hkrt_dp.sv
`default_nettype none

module hkrt_dp
   import hkrt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctl_cmd_type ctl_cmd,
   input  wire logic [1:0]  command,
   input  wire logic [7:0]  key_code,
   input  wire logic [7:0]  modifier_bits,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   output report_type       report
);

   logic [CODE_W-1:0]     slot_ff [SLOT_COUNT];
   logic [CODE_W-1:0]     slot_in [SLOT_COUNT];
   logic [7:0]            report_id_ff;
   logic [SLOT_COUNT-1:0] free_oh;
   logic                  found;
   logic                  hit;
   logic                  in_rollover;
   logic [7:0]            mods;
   report_type            report_ff, report_in;

   always_comb begin
      hit     = 1'b0;
      found   = 1'b0;
      free_oh = '0;
      // parallel compares, lowest empty slot wins
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slot_ff[i] == key_code) hit = 1'b1;
         if (!found && (slot_ff[i] == CODE_NONE)) begin
            free_oh[i] = 1'b1;
            found      = 1'b1;
         end
      end
   end

   assign in_rollover = (slot_ff[0] == CODE_ROLLOVER);

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) slot_in[i] = slot_ff[i];
      mods = modifier_bits;
      case (cmd_type'(command))
         CMD_CLEAR: begin
            for (int i = 0; i < SLOT_COUNT; i++) slot_in[i] = CODE_NONE;
            mods = '0;
         end
         CMD_PRESS: begin
            if ((key_code != CODE_NONE) && !hit) begin
               if (found) begin
                  for (int i = 0; i < SLOT_COUNT; i++)
                     if (free_oh[i]) slot_in[i] = key_code;
               end else begin
                  for (int i = 0; i < SLOT_COUNT; i++) slot_in[i] = CODE_ROLLOVER;
               end
            end
         end
         CMD_RELEASE: begin
            if (in_rollover) begin
               for (int i = 0; i < SLOT_COUNT; i++) slot_in[i] = CODE_NONE;
            end else begin
               for (int i = 0; i < SLOT_COUNT; i++)
                  if (slot_ff[i] == key_code) slot_in[i] = CODE_NONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      report_in.tag   = report_id_ff;
      report_in.mods  = mods;
      report_in.codes = '0;
      for (int k = 0; k < REPORT_SLOTS; k++) begin
         if (k < SLOT_COUNT) report_in.codes[k] = slot_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         report_id_ff <= REPORT_ID_RST;
         for (int i = 0; i < SLOT_COUNT; i++) slot_ff[i] <= CODE_NONE;
      end else begin
         if (csr_wr_en) report_id_ff <= csr_wr_data;
         if (ctl_cmd.load) begin
            for (int i = 0; i < SLOT_COUNT; i++) slot_ff[i] <= slot_in[i];
         end
      end
   end

   // report word, held until taken
   always_ff @(posedge clock) begin
      if (ctl_cmd.load) report_ff <= report_in;
   end

   assign report = report_ff;

endmodule

`default_nettype wire

>>> tb/hid_keyboard_rollover_table_test.sv
`timescale 1ns / 100ps

module hid_keyboard_rollover_table_test;
   import hkrt_pkg::*;

   localparam int          CLOCK_PERIOD  = 10;
   localparam int          RESET_CYCLES  = 4;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          PHASE_EVENTS  = 210;
   localparam int          PHASE_COUNT   = 5;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          HOLD_AT_EVENT = 300;
   localparam int          DRAIN_CYCLES  = 8;
   localparam int          PRINT_LIMIT   = 40;
   localparam logic [1:0]  CMD_UNUSED    = 2'd3;
   localparam logic [7:0]  FIRST_POOL    = 8'h04;
   localparam int          POOL_SPAN     = 8;

   typedef struct {
      logic [1:0] cmd;
      logic [7:0] code;
      logic [7:0] mods;
      bit         typed;
      logic [7:0] want_mods;
      logic [7:0] want_slot;
   } event_row_type;

   localparam int DIRECTED_ROWS = 25;

   // typed rows: report id still at its reset value, all six slots equal
   event_row_type key_script [DIRECTED_ROWS] = '{
      '{CMD_PRESS,   8'h00, 8'hFF, 1'b1, 8'hFF, CODE_NONE},
      '{CMD_RELEASE, 8'h00, 8'h00, 1'b1, 8'h00, CODE_NONE},
      '{CMD_UNUSED,  8'hFF, 8'hA5, 1'b1, 8'hA5, CODE_NONE},
      '{CMD_PRESS,   8'h04, 8'h02, 1'b0, 8'h00, CODE_NONE},
      '{CMD_PRESS,   8'h04, 8'h40, 1'b0, 8'h00, CODE_NONE},
      '{CMD_PRESS,   8'h01, 8'h00, 1'b0, 8'h00, CODE_NONE},
      '{CMD_PRESS,   8'hFF, 8'h80, 1'b0, 8'h00, CODE_NONE},
      '{CMD_PRESS,   8'h80, 8'h01, 1'b0, 8'h00, CODE_NONE},
      '{CMD_PRESS,   8'h7F, 8'h10, 1'b0, 8'h00, CODE_NONE},
      '{CMD_PRESS,   8'h05, 8'h20, 1'b0, 8'h00, CODE_NONE},
      '{CMD_PRESS,   8'h06, 8'h00, 1'b1, 8'h00, CODE_ROLLOVER},
      '{CMD_PRESS,   8'h07, 8'hFF, 1'b0, 8'h00, CODE_NONE},
      '{CMD_UNUSED,  8'h00, 8'h5A, 1'b0, 8'h00, CODE_NONE},
      '{CMD_RELEASE, 8'h55, 8'h33, 1'b1, 8'h33, CODE_NONE},
      '{CMD_PRESS,   8'h10, 8'h00, 1'b0, 8'h00, CODE_NONE},
      '{CMD_PRESS,   8'h11, 8'h00, 1'b0, 8'h00, CODE_NONE},
      '{CMD_PRESS,   8'h12, 8'h00, 1'b0, 8'h00, CODE_NONE},
      '{CMD_RELEASE, 8'h11, 8'h00, 1'b0, 8'h00, CODE_NONE},
      '{CMD_PRESS,   8'h13, 8'h00, 1'b0, 8'h00, CODE_NONE},
      '{CMD_RELEASE, 8'h12, 8'hC3, 1'b0, 8'h00, CODE_NONE},
      '{CMD_CLEAR,   8'h10, 8'hFF, 1'b1, 8'h00, CODE_NONE},
      '{CMD_PRESS,   8'h01, 8'h00, 1'b0, 8'h00, CODE_NONE},
      '{CMD_PRESS,   8'h20, 8'h00, 1'b0, 8'h00, CODE_NONE},
      '{CMD_RELEASE, 8'h20, 8'h0F, 1'b1, 8'h0F, CODE_NONE},
      '{CMD_RELEASE, 8'h00, 8'h00, 1'b1, 8'h00, CODE_NONE}
   };

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   hkrt_req_if req_ch ();
   hkrt_rsp_if rsp_ch ();

   hid_keyboard_rollover_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [7:0]  held_codes [SLOT_COUNT];
   logic [7:0]  report_id_shadow;
   report_type  pending_reports [$];
   int          cycle_count;
   int          error_count;
   int          events_sent;
   int          reports_checked;
   int          rollover_entries;
   int          id_writes;
   bit          idle_on;
   bit          rx_hold;

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
                  pending_reports.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // advances the slot table by one event and returns the report it produces
   function automatic report_type next_report(input logic [1:0] cmd, input logic [7:0] code,
                                              input logic [7:0] mods);
      report_type rep;
      int         free_idx;
      bit         held;
      free_idx = -1;
      held     = 1'b0;
      case (cmd)
         CMD_CLEAR: begin
            foreach (held_codes[i]) held_codes[i] = CODE_NONE;
            mods = 8'h00;
         end
         CMD_PRESS: begin
            if (code != CODE_NONE) begin
               foreach (held_codes[i]) begin
                  if (held_codes[i] == code)
                     held = 1'b1;
                  else if (free_idx < 0 && held_codes[i] == CODE_NONE)
                     free_idx = i;
               end
               if (!held) begin
                  if (free_idx < 0) begin
                     foreach (held_codes[i]) held_codes[i] = CODE_ROLLOVER;
                     rollover_entries++;
                  end else begin
                     held_codes[free_idx] = code;
                  end
               end
            end
         end
         CMD_RELEASE: begin
            // slot 0 holding the error code means the whole table is in rollover
            if (held_codes[0] == CODE_ROLLOVER) begin
               foreach (held_codes[i]) held_codes[i] = CODE_NONE;
            end else begin
               foreach (held_codes[i])
                  if (held_codes[i] == code) held_codes[i] = CODE_NONE;
            end
         end
         default: ;
      endcase
      rep.tag  = report_id_shadow;
      rep.mods = mods;
      for (int k = 0; k < REPORT_SLOTS; k++)
         rep.codes[k] = (k < SLOT_COUNT) ? held_codes[k] : CODE_NONE;
      return rep;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_event(input logic [1:0] cmd, input logic [7:0] code,
                             input logic [7:0] mods, input bit typed,
                             input report_type typed_rep);
      int         gap;
      report_type predicted;
      gap = 0;
      if (idle_on && $urandom_range(0, 99) < 40)
         gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.command       <= cmd;
      req_ch.key_code      <= code;
      req_ch.modifier_bits <= mods;
      do @(posedge clock); while (!req_ch.ready);
      predicted = next_report(cmd, code, mods);
      pending_reports.push_back(typed ? typed_rep : predicted);
      events_sent++;
   endtask

   task automatic wait_drained();
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_report_id(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en        <= 1'b0;
      report_id_shadow  = value;
      id_writes++;
   endtask

   task automatic check_report();
      report_type got;
      report_type want;
      got.tag      = rsp_ch.report_tag;
      got.mods     = rsp_ch.report_modifiers;
      got.codes[0] = rsp_ch.slot_code_0;
      got.codes[1] = rsp_ch.slot_code_1;
      got.codes[2] = rsp_ch.slot_code_2;
      got.codes[3] = rsp_ch.slot_code_3;
      got.codes[4] = rsp_ch.slot_code_4;
      got.codes[5] = rsp_ch.slot_code_5;
      if (pending_reports.size() == 0) begin
         report_mismatch($sformatf("report with no event pending, tag %02h", got.tag));
      end else begin
         want = pending_reports.pop_front();
         reports_checked++;
         if (got.tag !== want.tag)
            report_mismatch($sformatf("report_tag got %02h want %02h", got.tag, want.tag));
         if (got.mods !== want.mods)
            report_mismatch($sformatf("report_modifiers got %02h want %02h",
                                      got.mods, want.mods));
         for (int k = 0; k < REPORT_SLOTS; k++)
            if (got.codes[k] !== want.codes[k])
               report_mismatch($sformatf("slot_code_%0d got %02h want %02h", k,
                                         got.codes[k], want.codes[k]));
      end
   endtask

   // report sink with random back-pressure
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            check_report();
         if (rx_hold) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!idle_on || $urandom_range(0, 99) < 65) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            stall_left   = pick_gap() - 1;
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   // long sink hold-off while events keep coming, fills the report register
   initial begin
      rx_hold = 1'b0;
      wait (events_sent >= HOLD_AT_EVENT);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   initial begin
      report_type typed_rep;
      report_type no_rep;
      logic [1:0] cmd;
      logic [7:0] code;
      logic [7:0] phase_ids [PHASE_COUNT];
      int         pick;

      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = 8'h00;
      req_ch.valid         = 1'b0;
      req_ch.command       = CMD_CLEAR;
      req_ch.key_code      = 8'h00;
      req_ch.modifier_bits = 8'h00;
      cycle_count          = 0;
      error_count          = 0;
      events_sent          = 0;
      reports_checked      = 0;
      rollover_entries     = 0;
      id_writes            = 0;
      idle_on              = 1'b1;
      report_id_shadow     = REPORT_ID_RST;
      no_rep               = '0;
      foreach (held_codes[i]) held_codes[i] = CODE_NONE;

      phase_ids[0] = 8'h00;
      phase_ids[1] = 8'hFF;
      phase_ids[2] = 8'($urandom_range(0, 255));
      phase_ids[3] = REPORT_ID_RST;
      phase_ids[4] = 8'($urandom_range(0, 255));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (key_script[r]) begin
         typed_rep.tag  = REPORT_ID_RST;
         typed_rep.mods = key_script[r].want_mods;
         for (int k = 0; k < REPORT_SLOTS; k++) typed_rep.codes[k] = key_script[r].want_slot;
         send_event(key_script[r].cmd, key_script[r].code, key_script[r].mods,
                    key_script[r].typed, typed_rep);
      end

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         req_ch.valid <= 1'b0;
         wait_drained();
         write_report_id(phase_ids[ph]);
         // one phase runs with no idling on either side
         idle_on <= (ph != 2);
         for (int n = 0; n < PHASE_EVENTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      cmd = CMD_PRESS;
            else if (pick < 88) cmd = CMD_RELEASE;
            else if (pick < 94) cmd = CMD_UNUSED;
            else                cmd = CMD_CLEAR;
            // a small pool of codes, larger than the table, drives it into rollover
            pick = $urandom_range(0, 99);
            if (pick < 75)      code = FIRST_POOL + 8'($urandom_range(0, POOL_SPAN));
            else if (pick < 80) code = CODE_NONE;
            else if (pick < 85) code = CODE_ROLLOVER;
            else                code = 8'($urandom_range(0, 255));
            send_event(cmd, code, 8'($urandom_range(0, 255)), 1'b0, no_rep);
         end
      end

      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0)
         report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));

      $display("checked %0d keyboard reports from %0d events, %0d report id writes",
               reports_checked, events_sent, id_writes);
      $display("table entered rollover %0d times, %0d mismatches", rollover_entries,
               error_count);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> hid_keyboard_rollover_table.f
+incdir+src
src/hkrt_pkg.sv
src/hkrt_chan_if.sv
src/hkrt_ctrl.sv
src/hkrt_dp.sv
src/hid_keyboard_rollover_table.sv
tb/hid_keyboard_rollover_table_test.sv
